// ===== hdl/pomp_pkg.sv =====
// ----------------------------------------------------------------------------
// pomp_pkg: shared types and constants for the moving-pivot pendulum
// Item layouts, fixed-point constants of the swing model and the table of
// friction factors.
// ----------------------------------------------------------------------------
package pomp_pkg;

    // Input item: pivot position in pixels
    typedef struct packed {
        logic [9:0] pivot_x;
        logic [9:0] pivot_y;
    } t_in_item;

    // Result item: sprite frame, angle and angular rate
    typedef struct packed {
        logic [7:0]         frame_index;
        logic [31:0]        angle_phase;
        logic signed [31:0] angular_rate;
    } t_out_item;

    // Parameter defaults
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;
    localparam int FRAME_COUNT_DEF   = 256;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Gravity in Q.10 pixels per frame squared
    localparam logic signed [22:0] GRAVITY_Q10 = 23'sd102;

    // Turn fraction per radian over the radius, 2^32 / (2 pi 82)
    localparam logic [23:0] TURN_PER_RAD = 24'd8336162;

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Friction factors (1 - f) in Q1.24; the last one leaves the rate alone
    function automatic logic [24:0] damp_factor(input logic [2:0] sel);
        logic [24:0] f;
        case (sel)
            3'd0:    f = 25'd16777048;
            3'd1:    f = 25'd16776377;
            3'd2:    f = 25'd16775538;
            3'd3:    f = 25'd16760439;
            3'd4:    f = 25'd16743662;
            3'd5:    f = 25'd16693330;
            3'd6:    f = 25'd16609444;
            default: f = 25'd16777216;
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/pendulum_on_moving_pivot_step.sv =====
// ----------------------------------------------------------------------------
// pendulum_on_moving_pivot_step: pendulum swinging from a moving pivot
// Once per frame takes the pivot position, forms the pivot acceleration,
// applies the resulting torque and friction to the angular rate and advances
// the angle. One shared 33x26 signed multiplier does all products.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload            | direction
//  ---------+---------------------+--------------------+----------
//  input    | i_valid / o_stall   | i_item (t_in_item) | in
//  result   | o_valid / i_stall   | o_item (t_out_item)| out
//  config   | i_cfg_we            | i_cfg_data [2:0]   | in
//
//  An item runs from acceptance until its result is loaded through two
//  sine evaluations of five multiplies each, then torque scaling, friction
//  and frame index, every multiply on the one shared multiplier. A new
//  item is accepted only once the sequencer has returned to idle. The
//  next item is accepted while a result waits; the sequencer stalls at
//  its last step only if that result has still not been taken. Reset is
//  synchronous, active low.
//
module pendulum_on_moving_pivot_step #(
    parameter int SCREEN_WIDTH  = pomp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pomp_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAME_COUNT   = pomp_pkg::FRAME_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pomp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output pomp_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_data
);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PH   = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_C    = 4'd3;
    localparam logic [3:0] ST_B    = 4'd4;
    localparam logic [3:0] ST_A    = 4'd5;
    localparam logic [3:0] ST_F    = 4'd6;
    localparam logic [3:0] ST_KH   = 4'd7;
    localparam logic [3:0] ST_KL   = 4'd8;
    localparam logic [3:0] ST_SAT  = 4'd9;
    localparam logic [3:0] ST_DAMP = 4'd10;
    localparam logic [3:0] ST_ANG  = 4'd11;
    localparam logic [3:0] ST_FRM  = 4'd12;

    localparam logic [13:0] FRAME_N = 14'(FRAME_COUNT);

    // Control and model state
    logic [3:0]         r_state, n_state;
    logic               r_ph, n_ph;
    logic               r_sel, n_sel;
    logic [2:0]         r_fric, n_fric;
    logic [9:0]         r_last_x, n_last_x;
    logic [9:0]         r_last_y, n_last_y;
    logic signed [10:0] r_last_vx, n_last_vx;
    logic signed [10:0] r_last_vy, n_last_vy;
    logic signed [31:0] r_rate, n_rate;
    logic [31:0]        r_angle, n_angle;
    logic               r_ovalid, n_ovalid;

    // Datapath registers
    logic signed [21:0]              r_ax, n_ax;
    logic signed [22:0]              r_ay, n_ay;
    logic [15:0]                     r_xx, n_xx;
    logic                            r_neg, n_neg;
    logic [15:0]                     r_x2, n_x2;
    logic [16:0]                     r_t, n_t;
    logic signed [15:0]              r_sin, n_sin;
    logic signed [38:0]              r_torque, n_torque;
    logic signed [63:0]              r_acc, n_acc;
    logic signed [31:0]              r_rsat, n_rsat;
    logic signed [pomp_pkg::MUL_P_W-1:0] r_prod, n_prod;
    pomp_pkg::t_out_item             r_out, n_out;

    // Combinational helpers
    logic signed [pomp_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [pomp_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [pomp_pkg::MUL_P_W-1:0] w_prod;
    logic signed [10:0] w_dx, w_dy;
    logic signed [11:0] w_ddx, w_ddy;
    logic [31:0]        w_phase;
    logic [16:0]        w_s17;
    logic [15:0]        w_smag;
    logic signed [38:0] w_accel;
    logic signed [39:0] w_sum;
    logic signed [pomp_pkg::MUL_P_W-1:0] w_rnd;
    logic [45:0]        w_fsum;
    logic [13:0]        w_frame;
    logic               w_accept;
    logic               w_load;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_item   = r_out;

    // Pivot velocity and acceleration of the incoming item
    assign w_dx  = $signed({1'b0, i_item.pivot_x}) - $signed({1'b0, r_last_x});
    assign w_dy  = $signed({1'b0, i_item.pivot_y}) - $signed({1'b0, r_last_y});
    assign w_ddx = $signed({w_dx[10], w_dx}) - $signed({r_last_vx[10], r_last_vx});
    assign w_ddy = $signed({w_dy[10], w_dy}) - $signed({r_last_vy[10], r_last_vy});

    // Phase of the current sine: cosine first, then sine
    assign w_phase = r_sel ? r_angle : r_angle + pomp_pkg::QUARTER_TURN;

    // Select multiplier operands by step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_SQ: begin
                w_mul_a = $signed({17'd0, r_xx});
                w_mul_b = $signed({10'd0, r_xx});
            end
            ST_C: begin
                w_mul_a = $signed({20'd0, pomp_pkg::SIN_C});
                w_mul_b = $signed({10'd0, r_x2});
            end
            ST_B: begin
                w_mul_a = $signed({16'd0, r_t});
                w_mul_b = $signed({10'd0, r_x2});
            end
            ST_A: begin
                w_mul_a = $signed({16'd0, r_t});
                w_mul_b = $signed({10'd0, r_xx});
            end
            ST_F: begin
                w_mul_a = r_sel ? $signed({{10{r_ay[22]}}, r_ay})
                                : $signed({{11{r_ax[21]}}, r_ax});
                w_mul_b = $signed({{10{r_sin[15]}}, r_sin});
            end
            ST_KH: begin
                w_mul_a = $signed({{14{r_torque[38]}}, r_torque[38:20]});
                w_mul_b = $signed({2'd0, pomp_pkg::TURN_PER_RAD});
            end
            ST_KL: begin
                w_mul_a = $signed({13'd0, r_torque[19:0]});
                w_mul_b = $signed({2'd0, pomp_pkg::TURN_PER_RAD});
            end
            ST_DAMP: begin
                w_mul_a = $signed({r_rsat[31], r_rsat});
                w_mul_b = $signed({1'b0, pomp_pkg::damp_factor(r_fric)});
            end
            ST_FRM: begin
                w_mul_a = $signed({1'b0, r_angle});
                w_mul_b = $signed(26'(FRAME_COUNT));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Shared multiplier
    assign w_prod = w_mul_a * w_mul_b;

    // Post-processing of the registered product
    assign w_s17   = r_prod[32:16];
    assign w_smag  = (w_s17 > 17'd32767) ? 16'd32767 : w_s17[15:0];
    assign w_accel = r_acc[63:25];
    assign w_sum   = $signed({{8{r_rate[31]}}, r_rate}) + $signed({w_accel[38], w_accel});
    assign w_rnd   = r_prod + $signed(59'd8388608);
    assign w_fsum  = r_prod[45:0] + 46'h0_8000_0000;
    assign w_frame = w_fsum[45:32];

    // Sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_ph      = r_ph;
        n_sel     = r_sel;
        n_fric    = i_cfg_we ? i_cfg_data : r_fric;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        n_last_vx = r_last_vx;
        n_last_vy = r_last_vy;
        n_rate    = r_rate;
        n_angle   = r_angle;
        n_ovalid  = r_ovalid && i_stall;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_xx      = r_xx;
        n_neg     = r_neg;
        n_x2      = r_x2;
        n_t       = r_t;
        n_sin     = r_sin;
        n_torque  = r_torque;
        n_acc     = r_acc;
        n_rsat    = r_rsat;
        n_prod    = w_prod;
        n_out     = r_out;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last_x  = i_item.pivot_x;
                    n_last_y  = i_item.pivot_y;
                    n_last_vx = w_dx;
                    n_last_vy = w_dy;
                    n_ax      = $signed({w_ddx, 10'd0});
                    n_ay      = $signed({w_ddy[11], w_ddy, 10'd0}) - pomp_pkg::GRAVITY_Q10;
                    n_torque  = '0;
                    n_sel     = 1'b0;
                    n_ph      = 1'b0;
                    n_state   = ST_PH;
                end
            end
            ST_PH: begin
                // Fold the phase into the first quadrant
                n_xx    = w_phase[30] ? 16'd32768 - {1'b0, w_phase[29:15]}
                                      : {1'b0, w_phase[29:15]};
                n_neg   = w_phase[31];
                n_state = ST_SQ;
            end
            ST_SQ: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_x2    = r_prod[30:15];
                    n_state = ST_C;
                end
            end
            ST_C: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_t     = pomp_pkg::SIN_B - r_prod[31:15];
                    n_state = ST_B;
                end
            end
            ST_B: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_t     = pomp_pkg::SIN_A - r_prod[31:15];
                    n_state = ST_A;
                end
            end
            ST_A: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_sin   = r_neg ? -$signed(w_smag) : $signed(w_smag);
                    n_state = ST_F;
                end
            end
            ST_F: begin
                // Accumulate ax*cos, then ay*sin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_torque = r_torque + r_prod[38:0];
                    if (r_sel) begin
                        n_state = ST_KH;
                    end else begin
                        n_sel   = 1'b1;
                        n_state = ST_PH;
                    end
                end
            end
            ST_KH: begin
                // Upper torque half, with the rounding bias of the shift by 25
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc   = $signed({r_prod[43:0], 20'd0}) + 64'sd16777216;
                    n_state = ST_KL;
                end
            end
            ST_KL: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc   = r_acc + $signed({{5{r_prod[58]}}, r_prod});
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                // Add acceleration to rate and saturate to 32 bits
                if (w_sum[39:31] == 9'd0 || w_sum[39:31] == 9'h1FF) begin
                    n_rsat = w_sum[31:0];
                end else if (w_sum[39]) begin
                    n_rsat = 32'sh8000_0000;
                end else begin
                    n_rsat = 32'sh7FFF_FFFF;
                end
                n_state = ST_DAMP;
            end
            ST_DAMP: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_rate  = w_rnd[55:24];
                    n_state = ST_ANG;
                end
            end
            ST_ANG: begin
                n_angle = r_angle + r_rate;
                n_state = ST_FRM;
            end
            ST_FRM: begin
                // Round to a frame, then hand over once the output is free
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_prod = r_prod;
                    if (w_load) begin
                        n_out.frame_index  = (w_frame == FRAME_N) ? 8'd0 : w_frame[7:0];
                        n_out.angle_phase  = r_angle;
                        n_out.angular_rate = r_rate;
                        n_ovalid           = 1'b1;
                        n_ph               = 1'b0;
                        n_state            = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ph    = 1'b0;
            end
        endcase
    end

    // Control and model state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ph      <= 1'b0;
            r_sel     <= 1'b0;
            r_fric    <= 3'd0;
            r_last_x  <= 10'(SCREEN_WIDTH / 2);
            r_last_y  <= 10'(SCREEN_HEIGHT / 2);
            r_last_vx <= '0;
            r_last_vy <= '0;
            r_rate    <= '0;
            r_angle   <= pomp_pkg::HALF_TURN;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ph      <= n_ph;
            r_sel     <= n_sel;
            r_fric    <= n_fric;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
            r_last_vx <= n_last_vx;
            r_last_vy <= n_last_vy;
            r_rate    <= n_rate;
            r_angle   <= n_angle;
            r_ovalid  <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_xx     <= n_xx;
        r_neg    <= n_neg;
        r_x2     <= n_x2;
        r_t      <= n_t;
        r_sin    <= n_sin;
        r_torque <= n_torque;
        r_acc    <= n_acc;
        r_rsat   <= n_rsat;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    // Accepted item starts the first sine
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_PH)
        else $error("accepted item did not start the sequence");

    // Clamped sine never reaches the negative full scale
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_F |-> r_sin != 16'sh8000)
        else $error("sine out of range");

    // Friction never grows the rate magnitude nor flips its sign
    a_damp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ANG |->
            ((r_rsat >= 0 && r_rate >= 0 && r_rate <= r_rsat) ||
             (r_rsat < 0 && r_rate <= 0 && r_rate >= r_rsat)))
        else $error("damped rate exceeds saturated rate");

    // A freshly loaded result carries the current angle and rate
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_item.angle_phase == r_angle && o_item.angular_rate == r_rate)
        else $error("result does not match state");

endmodule

// ===== verif/pendulum_on_moving_pivot_step_tb.sv =====
// ----------------------------------------------------------------------------
// pendulum_on_moving_pivot_step_tb: self-checking bench for the swing stepper
// Feeds pivot positions through the valid/stall input channel, predicts each
// frame's angle, rate and sprite index with an independent fixed-point model
// of the pendulum, and compares every result item field by field. Covers
// still and jumping pivots, rate saturation in both directions, all friction
// settings and random pivot paths under several idle and stall mixes.
// ----------------------------------------------------------------------------
module pendulum_on_moving_pivot_step_tb;

    // Model constants
    localparam int     PIVOT_X0      = 160;
    localparam int     PIVOT_Y0      = 100;
    localparam longint GRAV_Q10      = 102;
    localparam longint RAD_TO_TURN   = 8336162;
    localparam longint POLY_K1       = 102944;
    localparam longint POLY_K3       = 42048;
    localparam longint POLY_K5       = 4640;
    localparam longint SINE_MAX      = 32767;
    localparam longint HALF_Q25      = 64'sd16777216;
    localparam longint HALF_Q24      = 64'sd8388608;
    localparam longint RATE_MAX      = 64'sd2147483647;
    localparam longint RATE_MIN      = -64'sd2147483648;
    localparam logic [31:0] ANGLE_DOWN = 32'h8000_0000;
    localparam logic [31:0] QUARTER    = 32'h4000_0000;
    localparam logic [2:0]  FRIC_LIGHTEST = 3'd0;
    localparam logic [2:0]  FRIC_HEAVIEST = 3'd6;
    localparam logic [2:0]  FRIC_NONE     = 3'd7;
    localparam int     END_SETTLE    = 40;
    localparam int     PRINT_CAP     = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    pomp_pkg::t_in_item   i_item;
    logic                 o_valid;
    logic                 i_stall;
    pomp_pkg::t_out_item  o_item;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_data;

    // Predicted pendulum state
    int          pv_last_x;
    int          pv_last_y;
    int          pv_last_vx;
    int          pv_last_vy;
    int          pv_rate;
    logic [31:0] pv_angle;
    logic [2:0]  pv_friction;

    pomp_pkg::t_out_item pending_frames[$];
    int mismatch_count;
    int frame_count;
    int idle_pct;
    int stall_pct;
    int walk_x;
    int walk_y;

    pendulum_on_moving_pivot_step i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #20_000_000;
        $display("pendulum_on_moving_pivot_step_tb failed");
        $finish;
    end

    // Quarter-wave polynomial, x in Q15 over one quarter turn
    function automatic longint quarter_wave(input longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 15;
        t  = (POLY_K5 * x2) >>> 15;
        t  = POLY_K3 - t;
        t  = (t * x2) >>> 15;
        t  = POLY_K1 - t;
        t  = (t * x) >>> 16;
        if (t > SINE_MAX)
            t = SINE_MAX;
        return t;
    endfunction

    function automatic longint sine_q15(input logic [31:0] ph);
        longint x;
        longint s;
        x = longint'(ph[29:15]);
        if (ph[30])
            s = quarter_wave(32768 - x);
        else
            s = quarter_wave(x);
        return ph[31] ? -s : s;
    endfunction

    // Advance the predicted pendulum by one pivot item
    function automatic pomp_pkg::t_out_item advance_swing(input pomp_pkg::t_in_item it);
        pomp_pkg::t_out_item res;
        int          x;
        int          y;
        int          vx;
        int          vy;
        longint      ax;
        longint      ay;
        longint      torque;
        longint      accel;
        longint      rate;
        longint      damp;
        logic [63:0] idx;
        x  = int'(it.pivot_x);
        y  = int'(it.pivot_y);
        vx = x - pv_last_x;
        vy = y - pv_last_y;
        ax = longint'(vx - pv_last_vx) * 1024;
        ay = longint'(vy - pv_last_vy) * 1024 - GRAV_Q10;
        pv_last_x  = x;
        pv_last_y  = y;
        pv_last_vx = vx;
        pv_last_vy = vy;

        torque = ax * sine_q15(pv_angle + QUARTER) + ay * sine_q15(pv_angle);
        accel  = (torque * RAD_TO_TURN + HALF_Q25) >>> 25;

        // saturate, then damp
        rate = longint'(pv_rate) + accel;
        if (rate > RATE_MAX)
            rate = RATE_MAX;
        if (rate < RATE_MIN)
            rate = RATE_MIN;
        case (pv_friction)
            3'd0:    damp = 16777048;
            3'd1:    damp = 16776377;
            3'd2:    damp = 16775538;
            3'd3:    damp = 16760439;
            3'd4:    damp = 16743662;
            3'd5:    damp = 16693330;
            3'd6:    damp = 16609444;
            default: damp = 16777216;
        endcase
        rate     = (rate * damp + HALF_Q24) >>> 24;
        pv_rate  = int'(rate);
        pv_angle = pv_angle + 32'(pv_rate);

        idx = ({32'd0, pv_angle} * 64'd256 + 64'h8000_0000) >> 32;
        res.frame_index  = idx[7:0];
        res.angle_phase  = pv_angle;
        res.angular_rate = pv_rate;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at frame %0d: %s got %0h expected %0h",
                     frame_count, field, got, want);
        mismatch_count++;
    endtask

    // Check each accepted result item against the oldest prediction
    always @(posedge i_clk) begin
        pomp_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected item", o_item.angle_phase, 32'd0);
            end else begin
                want = pending_frames.pop_front();
                if (o_item.frame_index != want.frame_index)
                    report_mismatch("frame_index", 32'(o_item.frame_index),
                                    32'(want.frame_index));
                if (o_item.angle_phase != want.angle_phase)
                    report_mismatch("angle_phase", o_item.angle_phase, want.angle_phase);
                if (o_item.angular_rate != want.angular_rate)
                    report_mismatch("angular_rate", o_item.angular_rate,
                                    want.angular_rate);
            end
            frame_count++;
        end
    end

    // Random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Send one pivot item, idling at random first
    task automatic push_pivot(input int x, input int y);
        pomp_pkg::t_in_item it;
        it.pivot_x = 10'(x);
        it.pivot_y = 10'(y);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        pending_frames.push_back(advance_swing(it));
    endtask

    // Hold the sender until every predicted frame has come back
    task automatic drain_frames();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_friction(input logic [2:0] sel);
        drain_frames();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sel;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pv_friction = sel;
    endtask

    // Mostly smooth pivot drift, with occasional jumps anywhere on screen
    task automatic push_walk();
        if ($urandom_range(99) < 15) begin
            walk_x = $urandom_range(1023);
            walk_y = $urandom_range(1023);
        end else begin
            walk_x += int'($urandom_range(16)) - 8;
            walk_y += int'($urandom_range(16)) - 8;
            if (walk_x < 0) walk_x = 0;
            if (walk_x > 1023) walk_x = 1023;
            if (walk_y < 0) walk_y = 0;
            if (walk_y > 1023) walk_y = 1023;
        end
        push_pivot(walk_x, walk_y);
    endtask

    // Pivot held at its reset position: gravity alone acts
    task automatic test_still_pivot();
        repeat (4) push_pivot(PIVOT_X0, PIVOT_Y0);
    endtask

    // Corner positions and full-screen jumps
    task automatic test_field_extremes();
        push_pivot(0, 0);
        push_pivot(1023, 1023);
        push_pivot(0, 1023);
        push_pivot(1023, 0);
        push_pivot(1023, 1023);
        push_pivot(0, 0);
        push_pivot(512, 512);
        push_pivot(PIVOT_X0, PIVOT_Y0);
    endtask

    // Large reversals drive the rate into both saturation limits
    task automatic test_rate_saturation();
        write_friction(FRIC_NONE);
        push_pivot(0, 511);
        push_pivot(1023, 0);
        push_pivot(0, 1023);
        push_pivot(1023, 0);
        push_pivot(0, 1023);
        push_pivot(1023, 1023);
        push_pivot(0, 0);
        push_pivot(1023, 1023);
    endtask

    // Every friction setting with a short random path
    task automatic test_friction_sweep();
        for (int s = 0; s < 8; s++) begin
            write_friction(3'(s));
            repeat (20) push_walk();
        end
    endtask

    // Long random paths under each idle and stall mix
    task automatic test_random_paths();
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 55, 0, 12};
        stall_mix = '{0, 0, 55, 12};
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       write_friction(FRIC_NONE);
                1:       write_friction(FRIC_LIGHTEST);
                2:       write_friction(FRIC_HEAVIEST);
                default: write_friction(3'($urandom_range(7)));
            endcase
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            repeat (340) push_walk();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_item     <= '0;
        i_stall    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        frame_count    = 0;
        walk_x         = PIVOT_X0;
        walk_y         = PIVOT_Y0;
        pv_last_x      = PIVOT_X0;
        pv_last_y      = PIVOT_Y0;
        pv_last_vx     = 0;
        pv_last_vy     = 0;
        pv_rate        = 0;
        pv_angle       = ANGLE_DOWN;
        pv_friction    = FRIC_LIGHTEST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_still_pivot();
        test_field_extremes();
        test_rate_saturation();
        test_friction_sweep();
        test_random_paths();

        // let the last frames drain, then settle
        drain_frames();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("pendulum_on_moving_pivot_step_tb passed");
        else
            $display("pendulum_on_moving_pivot_step_tb failed");
        $finish;
    end

endmodule
